### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that prop holds at every rising edge outside reset.
`define BDEQ_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that expr is never true outside reset.
`define BDEQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define BDEQ_ASSERT(lbl, clk, rst_n, prop, msg)

`define BDEQ_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

### sv/bdeq_pkg.sv
// ----------------------------------------------------------------------------
// bdeq_pkg
// Shared constants, types and index helpers of the byte deque.
// ----------------------------------------------------------------------------
package bdeq_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int OP_W     = 2;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;         // input beat accepted this cycle
    logic finish_read;  // store read data is valid, move it to the output
  } bdeq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic needs_read;   // current input is a pop on a non-empty deque
  } bdeq_sts_t;

  // Wrap a sum below twice the capacity back into the index range.
  function automatic idx_t wrap_idx(input logic [IDX_W:0] sum);
    logic [IDX_W:0] cap_x;
    logic [IDX_W:0] red;
    cap_x = (IDX_W + 1)'(CAPACITY);
    red   = (sum >= cap_x) ? (sum - cap_x) : sum;
    return red[IDX_W-1:0];
  endfunction

endpackage

### sv/bdeq_if.sv
// ----------------------------------------------------------------------------
// bdeq_if
// Valid/ready channels for deque operations and their results.
// ----------------------------------------------------------------------------
interface bdeq_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] push_byte;

  modport source (output valid, output opcode, output push_byte, input ready);
  modport sink   (input valid, input opcode, input push_byte, output ready);
endinterface

interface bdeq_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pop_byte;
  logic [1:0] status;
  logic [6:0] occupancy;

  modport source (output valid, output pop_byte, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_byte, input status, input occupancy,
                  output ready);
endinterface

### sv/bdeq_ctrl.sv
// ----------------------------------------------------------------------------
// bdeq_ctrl
// Sequencer: accepts operations, waits out the store read on pops and
// owns the output valid flag.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdeq_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_ready_i,
  input  bdeq_pkg::bdeq_sts_t sts_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  output bdeq_pkg::bdeq_cmd_t cmd_o
);
  import bdeq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic exec;
  logic load_out;

  // Take a beat only when the output slot is free or drains this cycle.
  assign in_ready_o = (state_q == S_IDLE) && (!out_valid_q || out_ready_i);
  assign exec       = in_valid_i && in_ready_o;
  assign load_out   = (exec && !sts_i.needs_read) || (state_q == S_READ);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (exec && sts_i.needs_read) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cmd_o.exec        = exec;
  assign cmd_o.finish_read = (state_q == S_READ);

  `BDEQ_ASSERT(a_pop_goes_to_read, clk_i, rst_ni, exec && sts_i.needs_read |=> state_q == S_READ, "pop did not wait for store read")
  `BDEQ_ASSERT_NEVER(a_read_slot_free, clk_i, rst_ni, state_q == S_READ && out_valid_q, "output slot busy when pop data arrives")
  `BDEQ_ASSERT(a_direct_result, clk_i, rst_ni, exec && !sts_i.needs_read |=> out_valid_q, "immediate result not presented")

endmodule

### sv/bdeq_dp.sv
// ----------------------------------------------------------------------------
// bdeq_dp
// Datapath: circular byte store, head pointer, fill count and result
// registers.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bdeq_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bdeq_pkg::bdeq_cmd_t                 cmd_i,
  input  logic [bdeq_pkg::OP_W-1:0]           opcode_i,
  input  logic [bdeq_pkg::BYTE_W-1:0]         push_byte_i,
  output bdeq_pkg::bdeq_sts_t                 sts_o,
  output logic [bdeq_pkg::BYTE_W-1:0]         pop_byte_o,
  output logic [bdeq_pkg::STATUS_W-1:0]       status_o,
  output logic [bdeq_pkg::OCC_W-1:0]          occupancy_o
);
  import bdeq_pkg::*;

  logic [BYTE_W-1:0] mem_q [CAPACITY];
  logic [BYTE_W-1:0] rd_data_q;

  idx_t head_q, head_d;
  cnt_t count_q, count_d;

  logic [BYTE_W-1:0]   out_byte_q;
  logic [STATUS_W-1:0] out_status_q;
  logic [OCC_W-1:0]    out_occ_q;

  logic full, empty;
  idx_t head_m1, head_p1, tail_idx, last_idx;
  logic [IDX_W:0] head_x, count_x, count_m1_x;

  logic              wr_en, rd_en;
  idx_t              wr_addr, rd_addr;
  logic [STATUS_W-1:0] res_status;
  logic [CNT_W+OCC_W-1:0] occ_ext;

  assign full  = (count_q == CNT_W'(CAPACITY));
  assign empty = (count_q == '0);
  assign sts_o.needs_read = opcode_i[1] && !empty;

  assign head_x     = (IDX_W + 1)'(head_q);
  assign count_x    = (IDX_W + 1)'(count_q);
  assign count_m1_x = (IDX_W + 1)'(count_q - CNT_W'(1));
  assign head_m1    = (head_q == '0) ? IDX_W'(CAPACITY - 1) : (head_q - IDX_W'(1));
  assign head_p1    = wrap_idx(head_x + (IDX_W + 1)'(1));
  assign tail_idx   = wrap_idx(head_x + count_x);
  assign last_idx   = wrap_idx(head_x + count_m1_x);

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = head_m1;
    rd_addr    = head_q;
    res_status = ST_DONE;
    if (cmd_i.exec) begin
      unique case (opcode_i)
        OP_PUSH_FRONT: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = head_m1;
            head_d  = head_m1;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            res_status = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = tail_idx;
            count_d = count_q + CNT_W'(1);
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = head_q;
            head_d  = head_p1;
            count_d = count_q - CNT_W'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            rd_en   = 1'b1;
            rd_addr = last_idx;
            count_d = count_q - CNT_W'(1);
          end
        end
      endcase
    end
  end

  // occupancy field carries the fill count after the operation
  assign occ_ext = {{OCC_W{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= push_byte_i;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // status and occupancy land at accept; a pop fills in its byte in the cycle after
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_byte_q   <= '0;
      out_status_q <= res_status;
      out_occ_q    <= occ_ext[OCC_W-1:0];
    end else if (cmd_i.finish_read) begin
      out_byte_q   <= rd_data_q;
    end
  end

  assign pop_byte_o  = out_byte_q;
  assign status_o    = out_status_q;
  assign occupancy_o = out_occ_q;

  `BDEQ_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(CAPACITY), "fill count beyond capacity")
  `BDEQ_ASSERT(a_full_push_holds, clk_i, rst_ni, cmd_i.exec && !opcode_i[1] && full |=> $stable(count_q) && $stable(head_q), "refused push changed deque state")
  `BDEQ_ASSERT_NEVER(a_no_rw_clash, clk_i, rst_ni, wr_en && rd_en, "store written and read in one cycle")

endmodule

### sv/byte_double_ended_queue_unit.sv
// ----------------------------------------------------------------------------
// byte_double_ended_queue_unit
// Bounded deque of bytes: push or pop at either end, one result per
// operation with popped byte, status and occupancy.
// ----------------------------------------------------------------------------
//  channel | dir | fields                          | beat
//  in_i    | in  | opcode, push_byte               | one operation
//  out_o   | out | pop_byte, status, occupancy     | one result
//
//  Push and refused operations: result valid the cycle after accept.
//  Successful pop: result valid once the registered store read is in the output.
//  Peak rate is one push per cycle while results drain; a pop holds off new
//  operations until its byte moves from the store into the output register.
//  Reset empties the deque at once (head and count cleared), no sweep.
//  A stalled result holds; new operations wait until the output slot drains.
// ----------------------------------------------------------------------------
module byte_double_ended_queue_unit (
  input logic        clk_i,
  input logic        rst_ni,
  bdeq_in_if.sink    in_i,
  bdeq_out_if.source out_o
);
  import bdeq_pkg::*;

  bdeq_cmd_t cmd;
  bdeq_sts_t sts;

  bdeq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  bdeq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .opcode_i    (in_i.opcode),
    .push_byte_i (in_i.push_byte),
    .sts_o       (sts),
    .pop_byte_o  (out_o.pop_byte),
    .status_o    (out_o.status),
    .occupancy_o (out_o.occupancy)
  );

endmodule
